// ===== rtl/json_string_unescape_utf8_core_defines.svh =====
// Assertion macros shared by the checker of the JSON string unescaper.
// Both macros expect clk and arst_n in scope.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// Types, codes and helpers for the JSON string unescaper.
// No dependencies; used by jsu_step, the top level and the checker jsu_chk.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

	typedef enum logic [2:0] {
		PH_PLAIN,
		PH_ESC,
		PH_HEX1,
		PH_WANT_BS,
		PH_WANT_U,
		PH_HEX2
	} phase_t;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_CTRL      = 4'd1;
	localparam logic [3:0] ERR_TRAIL_BS  = 4'd2;
	localparam logic [3:0] ERR_BAD_ESC   = 4'd3;
	localparam logic [3:0] ERR_BAD_HEX   = 4'd4;
	localparam logic [3:0] ERR_TRUNC     = 4'd5;
	localparam logic [3:0] ERR_INCOMPL   = 4'd6;
	localparam logic [3:0] ERR_BAD_LOW   = 4'd7;
	localparam logic [3:0] ERR_UNPAIRED  = 4'd8;

	localparam logic [7:0]  CTRL_LIMIT = 8'h20;
	localparam logic [15:0] HI_SUR_MIN = 16'hd800;
	localparam logic [15:0] HI_SUR_MAX = 16'hdbff;
	localparam logic [15:0] LO_SUR_MIN = 16'hdc00;
	localparam logic [15:0] LO_SUR_MAX = 16'hdfff;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;
	localparam logic [20:0] MAX_1BYTE  = 21'h7f;
	localparam logic [20:0] MAX_2BYTE  = 21'h7ff;
	localparam logic [20:0] MAX_3BYTE  = 21'hffff;

	typedef struct packed {
		phase_t       phase;
		logic [1:0]   digit_count;
		logic [15:0]  unit_accum;
		logic [9:0]   high_bits;
		logic         bad_digit_seen;
		logic         error_latched;
	} state_t;

	localparam state_t STATE_RST = '{PH_PLAIN, 2'd0, 16'd0, 10'd0, 1'b0, 1'b0};

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            data;
		logic [3:0]      err;
		logic            done;
	} res_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      len;
	} enc_t;

	function automatic enc_t utf8_enc(input logic [20:0] cp);
		enc_t e;
		e.bytes = '0;
		if (cp <= MAX_1BYTE) begin
			e.bytes[0] = cp[7:0];
			e.len = 3'd1;
		end else if (cp <= MAX_2BYTE) begin
			e.bytes[0] = {3'b110, cp[10:6]};
			e.bytes[1] = {2'b10, cp[5:0]};
			e.len = 3'd2;
		end else if (cp <= MAX_3BYTE) begin
			e.bytes[0] = {4'b1110, cp[15:12]};
			e.bytes[1] = {2'b10, cp[11:6]};
			e.bytes[2] = {2'b10, cp[5:0]};
			e.len = 3'd3;
		end else begin
			e.bytes[0] = {5'b11110, cp[20:18]};
			e.bytes[1] = {2'b10, cp[17:12]};
			e.bytes[2] = {2'b10, cp[11:6]};
			e.bytes[3] = {2'b10, cp[5:0]};
			e.len = 3'd4;
		end
		return e;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/json_string_unescape_utf8_core.sv =====
// Top level of the JSON string unescaper: decode step plus output result buffer.
// Depends on jsu_pkg and jsu_step.
`timescale 1ns / 1ps
`default_nettype none

// An input beat is decoded in the cycle it is accepted and its results (0 to 4)
// land in the output buffer, visible the next cycle. A beat yielding zero or one
// result sustains one beat per cycle while res_ready is high; a beat with more
// results holds the buffer until the last leaves, and the next input beat is
// taken in that cycle. The buffer, one result per cycle when res_ready, sets the rate.
module json_string_unescape_utf8_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       has_byte,
	input  logic       string_end,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       run_last,
	output logic [3:0] error_code,
	output logic       string_done
);

	jsu_pkg::state_t st_q;
	jsu_pkg::state_t st_nxt;
	jsu_pkg::res_t   res;

	logic [3:0][7:0] bytes_q;
	logic [2:0]      cnt_q;
	logic [1:0]      idx_q;
	logic            data_q;
	logic [3:0]      err_q;
	logic            done_q;
	logic [2:0]      cnt_m1;
	logic            last;
	logic            in_fire;
	logic            out_fire;

	jsu_step u_step (
		.st         (st_q),
		.in_byte    (in_byte),
		.has_byte   (has_byte),
		.string_end (string_end),
		.nxt        (st_nxt),
		.res        (res)
	);

	assign cnt_m1    = cnt_q - 3'd1;
	assign last      = (idx_q == cnt_m1[1:0]);
	assign res_valid = (cnt_q != 3'd0);
	assign in_ready  = ~res_valid | (res_ready & last);
	assign in_fire   = in_valid & in_ready;
	assign out_fire  = res_valid & res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= jsu_pkg::STATE_RST;
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (in_fire) begin
			st_q  <= st_nxt;
			cnt_q <= res.cnt;
			idx_q <= 2'd0;
		end else if (out_fire) begin
			if (last) begin
				cnt_q <= 3'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			bytes_q <= res.bytes;
			data_q  <= res.data;
			err_q   <= res.err;
			done_q  <= res.done;
		end
	end

	assign out_byte    = data_q ? bytes_q[idx_q] : 8'h00;
	assign out_valid   = data_q;
	assign run_last    = last;
	assign error_code  = err_q;
	assign string_done = done_q & last;

endmodule

`default_nettype wire

// ===== rtl/jsu_step.sv =====
// Next-state and result logic for one input beat of the unescaper.
// Purely combinational; depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_step (
	input  jsu_pkg::state_t st,
	input  logic [7:0]      in_byte,
	input  logic            has_byte,
	input  logic            string_end,
	output jsu_pkg::state_t nxt,
	output jsu_pkg::res_t   res
);

	logic [3:0]      hv;
	logic            hok;
	logic [15:0]     acc_new;
	logic            bad_new;
	logic            full;
	logic [3:0]      err;
	logic [2:0]      n;
	logic [3:0][7:0] buf_b;
	jsu_pkg::enc_t   enc_bmp;
	jsu_pkg::enc_t   enc_sup;
	logic [20:0]     cp_sup;

	always_comb begin
		hok = 1'b1;
		hv  = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hv = in_byte[3:0];
		end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
				(in_byte >= 8'h41 && in_byte <= 8'h46)) begin
			hv = in_byte[3:0] + 4'd9;
		end else begin
			hok = 1'b0;
		end
	end

	assign acc_new = {st.unit_accum[11:0], hv};
	assign bad_new = st.bad_digit_seen | ~hok;
	assign full    = (st.digit_count == 2'd3);
	assign cp_sup  = jsu_pkg::SUPP_BASE + {1'b0, st.high_bits, acc_new[9:0]};
	assign enc_bmp = jsu_pkg::utf8_enc({5'd0, acc_new});
	assign enc_sup = jsu_pkg::utf8_enc(cp_sup);

	always_comb begin
		nxt   = st;
		err   = jsu_pkg::ERR_NONE;
		n     = 3'd0;
		buf_b = '0;
		res   = '0;
		if (st.error_latched) begin
			if (string_end) begin
				nxt = jsu_pkg::STATE_RST;
			end
		end else begin
			if (has_byte) begin
				case (st.phase)
					jsu_pkg::PH_PLAIN: begin
						if (in_byte == 8'h5c) begin
							nxt.phase = jsu_pkg::PH_ESC;
						end else if (in_byte < jsu_pkg::CTRL_LIMIT) begin
							err = jsu_pkg::ERR_CTRL;
						end else begin
							buf_b[0] = in_byte;
							n = 3'd1;
						end
					end
					jsu_pkg::PH_ESC: begin
						nxt.phase = jsu_pkg::PH_PLAIN;
						n = 3'd1;
						case (in_byte)
							8'h22, 8'h5c, 8'h2f: buf_b[0] = in_byte;
							8'h62: buf_b[0] = 8'h08;
							8'h66: buf_b[0] = 8'h0c;
							8'h6e: buf_b[0] = 8'h0a;
							8'h72: buf_b[0] = 8'h0d;
							8'h74: buf_b[0] = 8'h09;
							8'h75: begin
								n = 3'd0;
								nxt.phase = jsu_pkg::PH_HEX1;
								nxt.digit_count = 2'd0;
								nxt.unit_accum = 16'd0;
								nxt.bad_digit_seen = 1'b0;
							end
							default: begin
								n = 3'd0;
								err = jsu_pkg::ERR_BAD_ESC;
							end
						endcase
					end
					jsu_pkg::PH_HEX1: begin
						nxt.unit_accum = acc_new;
						nxt.bad_digit_seen = bad_new;
						if (!full) begin
							nxt.digit_count = st.digit_count + 2'd1;
						end else if (bad_new) begin
							err = jsu_pkg::ERR_BAD_HEX;
						end else begin
							nxt.digit_count = 2'd0;
							nxt.unit_accum = 16'd0;
							if (acc_new >= jsu_pkg::HI_SUR_MIN &&
									acc_new <= jsu_pkg::HI_SUR_MAX) begin
								nxt.high_bits = acc_new[9:0];
								nxt.phase = jsu_pkg::PH_WANT_BS;
							end else if (acc_new >= jsu_pkg::LO_SUR_MIN &&
									acc_new <= jsu_pkg::LO_SUR_MAX) begin
								err = jsu_pkg::ERR_UNPAIRED;
							end else begin
								nxt.phase = jsu_pkg::PH_PLAIN;
								buf_b = enc_bmp.bytes;
								n = enc_bmp.len;
							end
						end
					end
					jsu_pkg::PH_WANT_BS: begin
						if (in_byte != 8'h5c) begin
							err = jsu_pkg::ERR_INCOMPL;
						end else begin
							nxt.phase = jsu_pkg::PH_WANT_U;
						end
					end
					jsu_pkg::PH_WANT_U: begin
						if (in_byte != 8'h75) begin
							err = jsu_pkg::ERR_INCOMPL;
						end else begin
							nxt.phase = jsu_pkg::PH_HEX2;
							nxt.digit_count = 2'd0;
							nxt.unit_accum = 16'd0;
							nxt.bad_digit_seen = 1'b0;
						end
					end
					default: begin
						nxt.unit_accum = acc_new;
						nxt.bad_digit_seen = bad_new;
						if (!full) begin
							nxt.digit_count = st.digit_count + 2'd1;
						end else if (bad_new) begin
							err = jsu_pkg::ERR_BAD_HEX;
						end else if (acc_new < jsu_pkg::LO_SUR_MIN ||
								acc_new > jsu_pkg::LO_SUR_MAX) begin
							err = jsu_pkg::ERR_BAD_LOW;
						end else begin
							nxt.phase = jsu_pkg::PH_PLAIN;
							nxt.digit_count = 2'd0;
							nxt.unit_accum = 16'd0;
							nxt.high_bits = 10'd0;
							buf_b = enc_sup.bytes;
							n = enc_sup.len;
						end
					end
				endcase
			end
			if (err == jsu_pkg::ERR_NONE && string_end && nxt.phase != jsu_pkg::PH_PLAIN) begin
				if (nxt.phase == jsu_pkg::PH_ESC) begin
					err = jsu_pkg::ERR_TRAIL_BS;
				end else if (nxt.phase == jsu_pkg::PH_HEX1) begin
					err = jsu_pkg::ERR_TRUNC;
				end else begin
					err = jsu_pkg::ERR_INCOMPL;
				end
			end
			if (err != jsu_pkg::ERR_NONE) begin
				res.cnt  = 3'd1;
				res.data = 1'b0;
				res.err  = err;
				res.done = 1'b1;
				nxt = jsu_pkg::STATE_RST;
				nxt.error_latched = ~string_end;
			end else begin
				res.bytes = buf_b;
				res.data  = (n != 3'd0);
				res.cnt   = (string_end && n == 3'd0) ? 3'd1 : n;
				res.done  = string_end;
				if (string_end) begin
					nxt = jsu_pkg::STATE_RST;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/jsu_chk.sv =====
// Port-level checker for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescape_utf8_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_utf8_core_defines.svh"

module jsu_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] out_byte,
	input logic       out_valid,
	input logic       run_last,
	input logic [3:0] error_code,
	input logic       string_done
);

	`JSU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result beat dropped")
	`JSU_ASSERT_NOW(a_data_no_err, res_valid && out_valid, error_code == jsu_pkg::ERR_NONE, "data with error")
	`JSU_ASSERT_NOW(a_err_form, res_valid && error_code != jsu_pkg::ERR_NONE,
		run_last && string_done && !out_valid, "malformed error beat")
	`JSU_ASSERT_NOW(a_done_last, res_valid && string_done, run_last, "done before last beat")
	`JSU_ASSERT_NOW(a_empty_zero, res_valid && !out_valid, out_byte == 8'h00, "byte on empty beat")

endmodule

bind json_string_unescape_utf8_core jsu_chk u_chk (.*);

`default_nettype wire
